@@ hdl/tzpa_pkg.sv @@
// shared types and constants for the tiled z-order pixel address block
package tzpa_pkg;

  // defaults for the top level parameters
  localparam int unsigned DEF_COORD_BITS      = 14;
  localparam int unsigned DEF_INTERLEAVE_BITS = 8;

  // configuration register widths and reset values
  localparam int unsigned WIDTH_W    = 15;
  localparam int unsigned BPE_W      = 7;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [WIDTH_W-1:0] RESET_SURFACE_WIDTH     = 15'd256;
  localparam logic [BPE_W-1:0]   RESET_BYTES_PER_ELEMENT = 7'd4;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_ELEMENT = 1'd1;

  // geometry
  localparam int unsigned LOG_W        = 3;   // holds log2 of edges and element sizes
  localparam int unsigned MIN_EDGE_LOG = 4;   // smallest tile edge is 16 pixels
  localparam int unsigned PER_ROW_W    = 12;  // tiles per row, up to 2048
  localparam int unsigned TILE_SHIFT   = 14;  // 16 KB per tile
  localparam int unsigned OFFSET_W     = 34;
  localparam int unsigned TILE_IDX_W   = OFFSET_W - TILE_SHIFT;

  // decoded surface geometry, handed from the config block to the datapath
  typedef struct packed {
    logic                 ok;
    logic [LOG_W-1:0]     sw_log;
    logic [LOG_W-1:0]     sh_log;
    logic [LOG_W-1:0]     bpe_log;
    logic [PER_ROW_W-1:0] per_row;
  } geom_t;

endpackage

@@ hdl/tzpa_cfg.sv @@
// configuration registers and registered decode of the surface geometry
module tzpa_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tzpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tzpa_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tzpa_pkg::geom_t                   geom
);
  import tzpa_pkg::*;

  logic [WIDTH_W-1:0] surface_width;
  logic [WIDTH_W-1:0] surface_width_next;
  logic [BPE_W-1:0]   bytes_per_element;
  logic [BPE_W-1:0]   bytes_per_element_next;

  function automatic geom_t decode_geom(input logic [WIDTH_W-1:0] w,
                                        input logic [BPE_W-1:0] bpe);
    geom_t         g;
    logic [WIDTH_W:0] sum;
    logic [WIDTH_W:0] shifted;
    g = '0;
    case (bpe)
      7'd1: begin
        g.ok = 1'b1; g.sw_log = 3'd7; g.sh_log = 3'd7; g.bpe_log = 3'd0;
      end
      7'd2: begin
        g.ok = 1'b1; g.sw_log = 3'd7; g.sh_log = 3'd6; g.bpe_log = 3'd1;
      end
      7'd4: begin
        g.ok = 1'b1; g.sw_log = 3'd6; g.sh_log = 3'd6; g.bpe_log = 3'd2;
      end
      7'd8: begin
        g.ok = 1'b1; g.sw_log = 3'd6; g.sh_log = 3'd5; g.bpe_log = 3'd3;
      end
      7'd16: begin
        g.ok = 1'b1; g.sw_log = 3'd5; g.sh_log = 3'd5; g.bpe_log = 3'd4;
      end
      7'd32: begin
        g.ok = 1'b1; g.sw_log = 3'd5; g.sh_log = 3'd4; g.bpe_log = 3'd5;
      end
      7'd64: begin
        g.ok = 1'b1; g.sw_log = 3'd4; g.sh_log = 3'd4; g.bpe_log = 3'd6;
      end
      default: begin
        g.ok = 1'b0; g.sw_log = 3'd4; g.sh_log = 3'd4; g.bpe_log = 3'd0;
      end
    endcase
    // round width up to whole tiles
    sum       = {1'b0, w} + (((WIDTH_W+1)'(1)) << g.sw_log) - (WIDTH_W+1)'(1);
    shifted   = sum >> g.sw_log;
    g.per_row = shifted[PER_ROW_W-1:0];
    return g;
  endfunction

  // register values after this edge's write, so the decode keeps pace
  always_comb begin
    surface_width_next     = surface_width;
    bytes_per_element_next = bytes_per_element;
    if (cfg_we && cfg_index == REG_SURFACE_WIDTH) begin
      surface_width_next = cfg_data[WIDTH_W-1:0];
    end
    if (cfg_we && cfg_index == REG_BYTES_PER_ELEMENT) begin
      bytes_per_element_next = cfg_data[BPE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width     <= RESET_SURFACE_WIDTH;
      bytes_per_element <= RESET_BYTES_PER_ELEMENT;
      geom              <= decode_geom(RESET_SURFACE_WIDTH, RESET_BYTES_PER_ELEMENT);
    end else begin
      surface_width     <= surface_width_next;
      bytes_per_element <= bytes_per_element_next;
      geom              <= decode_geom(surface_width_next, bytes_per_element_next);
    end
  end

endmodule

@@ hdl/tiled_zorder_pixel_address_top.sv @@
// top level of the tiled z-order pixel address generator
//
// Turns a pixel coordinate into its byte offset in a tiled surface of 16 KB
// tiles. Tile edges follow bytes_per_element (1 to 64, powers of two); inside
// a tile pixels sit in morton order (x on even bits, y on odd), tiles run
// row-major and every tile row is padded to whole tiles of surface_width.
// Any other element size returns offset 0 with the bad_element_size flag set.
// One request is taken every cycle while s_tready is high; each result is
// registered in turn by the stages before it is presented on m_tdata
// (split slice / tile row multiply and morton spread / final add and output
// register). A stage holds only while the stage ahead of it is full and
// stalled, so requests are refused only when m_tready is low with all three
// stages full. A configuration write applies to every request taken after
// the edge of the write; write only while no request is in flight.
module tiled_zorder_pixel_address_top #(
  parameter int unsigned COORD_BITS      = tzpa_pkg::DEF_COORD_BITS,
  parameter int unsigned INTERLEAVE_BITS = tzpa_pkg::DEF_INTERLEAVE_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration write port
  input  logic                                    cfg_we,
  input  logic [tzpa_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tzpa_pkg::CFG_DATA_W-1:0]         cfg_data,
  // request side
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_tdata,   // pixel_x, pixel_y, zero pad
  // result side
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [((tzpa_pkg::OFFSET_W+7)/8)*8-1:0] m_tdata,   // byte_offset, zero pad
  output logic                                    m_tuser    // bad_element_size
);
  import tzpa_pkg::*;

  localparam int unsigned TILE_POS_W = COORD_BITS - MIN_EDGE_LOG;   // tile column / row
  localparam int unsigned ZW         = 2 * INTERLEAVE_BITS;         // morton code
  localparam int unsigned ZSH_W      = ZW + (1 << LOG_W);           // morton code after scaling
  localparam int unsigned PROD_W     = TILE_POS_W + PER_ROW_W;
  localparam int unsigned SUM_RAW_W  = PROD_W + 1;
  localparam int unsigned SUM_W      = (SUM_RAW_W > TILE_IDX_W) ? SUM_RAW_W : TILE_IDX_W;
  localparam int unsigned TDATA_OUT_W = ((OFFSET_W + 7) / 8) * 8;

  geom_t geom;

  tzpa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // request fields
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  assign pixel_x = s_tdata[COORD_BITS-1:0];
  assign pixel_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

  // per stage ready: a stage moves on when it is empty or the next one takes it
  logic rdy1, rdy2, rdy3;
  logic v1, v2, v3;

  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // stage 1: split the coordinate into tile position and position in tile
  logic                       ok1;
  logic [LOG_W-1:0]           bpe_log1;
  logic [PER_ROW_W-1:0]       per_row1;
  logic [TILE_POS_W-1:0]      tile_col1, tile_row1;
  logic [INTERLEAVE_BITS-1:0] lx1, ly1;

  logic [COORD_BITS-1:0]      col_shift, row_shift;
  logic [INTERLEAVE_BITS-1:0] xmask, ymask;

  always_comb begin
    col_shift = pixel_x >> geom.sw_log;
    row_shift = pixel_y >> geom.sh_log;
    xmask     = (INTERLEAVE_BITS'(1) << geom.sw_log) - INTERLEAVE_BITS'(1);
    ymask     = (INTERLEAVE_BITS'(1) << geom.sh_log) - INTERLEAVE_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      ok1       <= geom.ok;
      bpe_log1  <= geom.bpe_log;
      per_row1  <= geom.per_row;
      tile_col1 <= col_shift[TILE_POS_W-1:0];
      tile_row1 <= row_shift[TILE_POS_W-1:0];
      lx1       <= pixel_x[INTERLEAVE_BITS-1:0] & xmask;
      ly1       <= pixel_y[INTERLEAVE_BITS-1:0] & ymask;
    end
  end

  // stage 2: tile row times tiles per row, morton spread scaled by element size
  function automatic logic [ZW-1:0] morton(input logic [INTERLEAVE_BITS-1:0] lx,
                                           input logic [INTERLEAVE_BITS-1:0] ly);
    logic [ZW-1:0] z;
    z = '0;
    for (int i = 0; i < INTERLEAVE_BITS; i++) begin
      z[2*i]   = lx[i];
      z[2*i+1] = ly[i];
    end
    return z;
  endfunction

  logic                  ok2;
  logic [PROD_W-1:0]     prod2;
  logic [TILE_POS_W-1:0] tile_col2;
  logic [TILE_SHIFT-1:0] zb2;
  logic [ZSH_W-1:0]      zscaled;

  assign zscaled = ZSH_W'(morton(lx1, ly1)) << bpe_log1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      ok2       <= ok1;
      prod2     <= PROD_W'(tile_row1) * PROD_W'(per_row1);
      tile_col2 <= tile_col1;
      zb2       <= zscaled[TILE_SHIFT-1:0];
    end
  end

  // stage 3: tile index add and output register; the in-tile part never carries
  logic [SUM_W-1:0] tile_num;
  assign tile_num = SUM_W'(prod2) + SUM_W'(tile_col2);

  logic [OFFSET_W-1:0] offset3;
  logic                bad3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      bad3    <= !ok2;
      offset3 <= ok2 ? {tile_num[TILE_IDX_W-1:0], zb2} : '0;
    end
  end

  assign m_tvalid = v3;
  assign m_tuser  = bad3;
  assign m_tdata  = TDATA_OUT_W'(offset3);

  // a flagged result never carries an offset
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("bad element size result with non-zero offset");

  // requests are refused only when every stage holds an item
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3))
    else $error("request refused with a bubble in the pipe");

  // a held result keeps the stage behind it frozen
  assert property (@(posedge clk) disable iff (rst)
    (v3 && !m_tready && v2) |=> (v2 && $stable(prod2) && $stable(zb2)))
    else $error("stage two lost its item during a stall");

  // nothing comes out straight after reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

endmodule

@@ tb/sv/tiled_zorder_pixel_address_top_tb.sv @@
// self-checking stream testbench for the tiled z-order pixel address generator
module tiled_zorder_pixel_address_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tzpa_pkg::*;

  localparam int unsigned COORD_BITS = DEF_COORD_BITS;
  localparam int unsigned MORTON_BITS = DEF_INTERLEAVE_BITS;
  localparam int unsigned S_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned M_W = ((OFFSET_W + 7) / 8) * 8;
  // far beyond the slowest correct run: up to 762 requests under heavy stalls
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                bad;
  } offset_result_t;

  // expected offsets for accepted pixel requests, kept in arrival order
  class offset_scoreboard;
    offset_result_t      pending_offsets[$];
    logic [WIDTH_W-1:0]  width;
    logic [BPE_W-1:0]    bpe;
    int unsigned         errors;
    int unsigned         requests;
    int unsigned         checked;
    int unsigned         bad_seen;

    function new();
      width = RESET_SURFACE_WIDTH;
      bpe   = RESET_BYTES_PER_ELEMENT;
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_SURFACE_WIDTH) begin
        width = data[WIDTH_W-1:0];
      end else begin
        bpe = data[BPE_W-1:0];
      end
    endfunction

    // byte offset of a pixel under the current geometry
    function offset_result_t tiled_offset(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
      offset_result_t r;
      int unsigned    sw;
      int unsigned    sh;
      bit             ok;
      bit [63:0]      per_row;
      bit [63:0]      tile_num;
      bit [63:0]      z;
      bit [63:0]      full;
      ok = 1'b1;
      sw = 0;
      sh = 0;
      case (bpe)
        7'd1:    begin sw = 7; sh = 7; end
        7'd2:    begin sw = 7; sh = 6; end
        7'd4:    begin sw = 6; sh = 6; end
        7'd8:    begin sw = 6; sh = 5; end
        7'd16:   begin sw = 5; sh = 5; end
        7'd32:   begin sw = 5; sh = 4; end
        7'd64:   begin sw = 4; sh = 4; end
        default: ok = 1'b0;
      endcase
      r.bad    = !ok;
      r.offset = '0;
      if (ok) begin
        per_row  = (64'(width) + (64'd1 << sw) - 64'd1) >> sw;
        tile_num = 64'(y >> sh) * per_row + 64'(x >> sw);
        z = '0;
        for (int i = 0; i < MORTON_BITS; i++) begin
          if (i < sw) z[2*i] = x[i];
          if (i < sh) z[2*i+1] = y[i];
        end
        full     = (tile_num << TILE_SHIFT) + z * 64'(bpe);
        r.offset = full[OFFSET_W-1:0];
      end
      return r;
    endfunction

    function void note_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
      pending_offsets.push_back(tiled_offset(x, y));
      requests++;
    endfunction

    function int unsigned pending();
      return pending_offsets.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_offset(logic [OFFSET_W-1:0] offset, logic bad);
      offset_result_t want;
      if (pending_offsets.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0b with no request waiting", offset, bad));
      end else begin
        want = pending_offsets.pop_front();
        checked++;
        if (bad) bad_seen++;
        if (offset !== want.offset)
          report_mismatch($sformatf("result %0d: byte_offset %0d, expected %0d",
                                    checked, offset, want.offset));
        if (bad !== want.bad)
          report_mismatch($sformatf("result %0d: bad_element_size %0b, expected %0b",
                                    checked, bad, want.bad));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_W-1:0]        s_tdata;   // pixel_x, pixel_y, zero pad
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_W-1:0]        m_tdata;   // byte_offset, zero pad
  logic                  m_tuser;   // bad_element_size

  offset_scoreboard sb = new();

  // idle chances in percent, changed per phase of the run
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cfg_writes;
  int unsigned cycles;

  tiled_zorder_pixel_address_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // sample both handshakes at the edge; a request can never produce its
  // result in the same cycle, so noting before checking is safe
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_pixel(s_tdata[COORD_BITS-1:0], s_tdata[2*COORD_BITS-1:COORD_BITS]);
      if (m_tvalid && m_tready)
        sb.check_offset(m_tdata[OFFSET_W-1:0], m_tuser);
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // offer one pixel request, holding it until accepted; valid stays high
  // on return so back-to-back requests need no gap
  task send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    logic [S_W-1:0] word;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    word = '0;
    word[COORD_BITS-1:0] = x;
    word[2*COORD_BITS-1:COORD_BITS] = y;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending and wait until every outstanding result is back, plus the
  // pipe depth so nothing is still in flight
  task drain_pipe();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // single register write, with cfg_we dropped again before returning
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(idx, data);
    cfg_writes++;
    repeat (2) @(posedge clk);
  endtask

  task set_geometry(input logic [CFG_DATA_W-1:0] width, input logic [CFG_DATA_W-1:0] bpe_word);
    drain_pipe();
    write_reg(REG_SURFACE_WIDTH, width);
    write_reg(REG_BYTES_PER_ELEMENT, bpe_word);
  endtask

  // widths lean on the extremes: zero, one, the 16384 boundary and beyond
  function logic [CFG_DATA_W-1:0] pick_width();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 15'd1;
      2:       return 15'h7fff;
      3:       return 15'd16384;
      4:       return CFG_DATA_W'($urandom_range(16384, 1));
      default: return CFG_DATA_W'($urandom_range(32767));
    endcase
  endfunction

  // mostly supported sizes; the bits above the register are random noise
  function logic [CFG_DATA_W-1:0] pick_bpe();
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom_range(255)) << BPE_W;
    if ($urandom_range(99) < 85)
      word[BPE_W-1:0] = BPE_W'(1 << $urandom_range(6));
    else
      word[BPE_W-1:0] = BPE_W'($urandom_range(127));
    return word;
  endfunction

  // full range, small coordinates near the origin, tile boundaries and the two extremes
  function logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(4))
      0, 1:    return COORD_BITS'($urandom);
      2:       return COORD_BITS'($urandom_range(1023));
      3:       return COORD_BITS'((($urandom_range(255) + 1) << $urandom_range(7, 4)) - 1);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  initial begin
    int unsigned n;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_writes    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset geometry (width 256, 4 bytes), corners and tile edges
    send_pixel(14'd0, 14'd0);
    send_pixel(14'h3fff, 14'h3fff);
    send_pixel(14'd63, 14'd0);
    send_pixel(14'd64, 14'd0);
    send_pixel(14'd0, 14'd63);
    send_pixel(14'd0, 14'd64);
    send_pixel(14'h2aaa, 14'h1555);
    send_pixel(14'h1555, 14'h2aaa);

    // directed: the six supported sizes other than 4, zero width, overflowing widths,
    // unsupported sizes including zero and all ones
    set_geometry(15'd1, 15'd64);
    send_pixel(14'h3fff, 14'h3fff);
    send_pixel(14'd15, 14'd16);
    set_geometry(15'd0, 15'd16);
    send_pixel(14'h3fff, 14'h3fff);
    send_pixel(14'd31, 14'd31);
    set_geometry(15'h7fff, 15'd1);
    send_pixel(14'h3fff, 14'h3fff);
    send_pixel(14'd127, 14'd128);
    set_geometry(15'd16384, 15'd2);
    send_pixel(14'h3fff, 14'h3fff);
    send_pixel(14'd128, 14'd63);
    set_geometry(15'd777, 15'd8);
    send_pixel(14'h3fff, 14'h3fff);
    send_pixel(14'd900, 14'd33);
    set_geometry(15'd4095, 15'h7fa0);
    send_pixel(14'h3fff, 14'h3fff);
    send_pixel(14'd32, 14'd15);
    set_geometry(15'd2049, 15'd0);
    send_pixel(14'h3fff, 14'h3fff);
    send_pixel(14'd5, 14'd9);
    set_geometry(15'd2049, 15'd127);
    send_pixel(14'd0, 14'd0);
    send_pixel(14'd100, 14'd200);

    // random: three idling phases, each over several fresh geometries;
    // every geometry change first waits for the pipe to empty
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 18; recv_idle_pct = 82; end
        1:       begin send_idle_pct = 82; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < 6; seg++) begin
        set_geometry(pick_width(), pick_bpe());
        n = $urandom_range(41, 20);
        for (int k = 0; k < n; k++) send_pixel(pick_coord(), pick_coord());
      end
    end

    // let the last results out and give stray ones a chance to show
    drain_pipe();
    repeat (8) @(posedge clk);

    $display("covered %0d pixel requests over %0d register writes, all seven element sizes",
             sb.requests, cfg_writes);
    $display("plus unsupported sizes (%0d flagged results), zero and overflowing widths",
             sb.bad_seen);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tzpa_pkg.sv
hdl/tzpa_cfg.sv
hdl/tiled_zorder_pixel_address_top.sv
tb/sv/tiled_zorder_pixel_address_top_tb.sv
